// File: src/segx_pkg.sv
package segx_pkg;

  localparam int COORD_W = 16;
  localparam int OUT_W = 48;
  localparam int SUM_W = 64;
  localparam int QUO_LIM = 62;

  localparam logic signed [SUM_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

  localparam logic [1:0] KIND_STRICT = 2'd0;
  localparam logic [1:0] KIND_TOUCH  = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
    logic                    overflow;
  } seg_out_t;

  // sideband carried through the divider
  typedef struct packed {
    logic                      hit;
    logic                      use_q;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
  } side_t;

endpackage

// File: src/segment_intersection.sv
// Throughput: one item per cycle unless a full output skid stalls the pipe; the quotient comes
//   from a pipelined restoring divider, one quotient bit per stage, FRAC_BITS + 50 stages.
// A two-entry output skid keeps the pipe moving while a result waits.
// Reset clears the pipeline valid bits and the skid count; data registers are not reset.
module segment_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  segx_pkg::seg_in_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output segx_pkg::seg_out_t result
);

  localparam int CW   = segx_pkg::COORD_W;
  localparam int DFW  = CW + 1;
  localparam int PW   = 2 * DFW;
  localparam int DETW = PW + 1;
  // determinants of 17-bit differences stay below 2^33 in magnitude
  localparam int MAGW = DETW - 1;
  localparam int MW   = MAGW + CW;
  localparam int NW   = MW + FRAC_BITS;
  localparam int SW   = segx_pkg::SUM_W;
  localparam int OW   = segx_pkg::OUT_W;

  typedef struct packed {
    logic signed [OW-1:0] val;
    logic                 ovf;
  } axis_t;

  function automatic logic signed [DFW-1:0] dif(
    input logic signed [CW-1:0] a,
    input logic signed [CW-1:0] b
  );
    return DFW'(a) - DFW'(b);
  endfunction

  function automatic axis_t fix_axis(
    input logic [NW-1:0]        q,
    input logic                 neg,
    input logic                 use_q,
    input logic signed [CW-1:0] base
  );
    logic signed [SW-1:0] sq;
    logic signed [SW-1:0] bterm;
    logic signed [SW-1:0] sum;
    axis_t                r;
    sq    = neg ? -signed'(SW'(q)) : signed'(SW'(q));
    bterm = SW'(base) <<< FRAC_BITS;
    sum   = (use_q ? sq : '0) + bterm;
    r.ovf = 1'b0;
    r.val = sum[OW-1:0];
    if (use_q && (|(q >> segx_pkg::QUO_LIM))) begin
      r.ovf = 1'b1;
      r.val = neg ? segx_pkg::OUT_MIN[OW-1:0] : segx_pkg::OUT_MAX[OW-1:0];
    end else if (sum > segx_pkg::OUT_MAX) begin
      r.ovf = 1'b1;
      r.val = segx_pkg::OUT_MAX[OW-1:0];
    end else if (sum < segx_pkg::OUT_MIN) begin
      r.ovf = 1'b1;
      r.val = segx_pkg::OUT_MIN[OW-1:0];
    end
    return r;
  endfunction

  logic advance;
  logic div_valid;
  logic [1:0] cnt;

  assign advance    = (cnt != 2'd2) || !div_valid;
  assign item_stall = !advance;

  // stage 1: differences
  logic signed [CW-1:0] fx [4];
  logic signed [CW-1:0] fy [4];
  logic signed [CW-1:0] tx [4];
  logic signed [CW-1:0] ty [4];
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];

  always_comb begin
    // endpoint tests in priority order: B start on A, B end on A, A start on B, A end on B
    fx[0] = item.a_start_x; fy[0] = item.a_start_y;
    tx[0] = item.a_end_x;   ty[0] = item.a_end_y;
    px[0] = item.b_start_x; py[0] = item.b_start_y;
    fx[1] = item.a_start_x; fy[1] = item.a_start_y;
    tx[1] = item.a_end_x;   ty[1] = item.a_end_y;
    px[1] = item.b_end_x;   py[1] = item.b_end_y;
    fx[2] = item.b_start_x; fy[2] = item.b_start_y;
    tx[2] = item.b_end_x;   ty[2] = item.b_end_y;
    px[2] = item.a_start_x; py[2] = item.a_start_y;
    fx[3] = item.b_start_x; fy[3] = item.b_start_y;
    tx[3] = item.b_end_x;   ty[3] = item.b_end_y;
    px[3] = item.a_end_x;   py[3] = item.a_end_y;
  end

  logic                  v1;
  segx_pkg::seg_in_t     it1;
  logic signed [DFW-1:0] sx1, sy1, vx1, vy1, wx1, wy1;
  logic signed [DFW-1:0] ux1 [4];
  logic signed [DFW-1:0] uy1 [4];
  logic signed [DFW-1:0] tx1 [4];
  logic signed [DFW-1:0] ty1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      it1 <= item;
      sx1 <= dif(item.b_start_x, item.a_start_x);
      sy1 <= dif(item.b_start_y, item.a_start_y);
      vx1 <= dif(item.a_end_x, item.a_start_x);
      vy1 <= dif(item.a_end_y, item.a_start_y);
      wx1 <= dif(item.b_start_x, item.b_end_x);
      wy1 <= dif(item.b_start_y, item.b_end_y);
      for (int k = 0; k < 4; k++) begin
        ux1[k] <= dif(fx[k], px[k]);
        uy1[k] <= dif(fy[k], py[k]);
        tx1[k] <= dif(px[k], tx[k]);
        ty1[k] <= dif(py[k], ty[k]);
      end
    end
  end

  // stage 2: products
  logic                  v2;
  segx_pkg::seg_in_t     it2;
  logic signed [DFW-1:0] vx2, vy2;
  logic signed [PW-1:0]  pd1, pd2, pa1, pa2, pb1, pb2;
  logic signed [PW-1:0]  pc1 [4];
  logic signed [PW-1:0]  pc2 [4];
  logic signed [PW-1:0]  pt1 [4];
  logic signed [PW-1:0]  pt2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      it2 <= it1;
      vx2 <= vx1;
      vy2 <= vy1;
      pd1 <= PW'(vx1) * PW'(wy1);
      pd2 <= PW'(vy1) * PW'(wx1);
      pa1 <= PW'(sx1) * PW'(wy1);
      pa2 <= PW'(sy1) * PW'(wx1);
      pb1 <= PW'(vx1) * PW'(sy1);
      pb2 <= PW'(vy1) * PW'(sx1);
      for (int k = 0; k < 4; k++) begin
        pc1[k] <= PW'(ux1[k]) * PW'(ty1[k]);
        pc2[k] <= PW'(uy1[k]) * PW'(tx1[k]);
        pt1[k] <= PW'(ux1[k]) * PW'(tx1[k]);
        pt2[k] <= PW'(uy1[k]) * PW'(ty1[k]);
      end
    end
  end

  // stage 3: determinants and on-segment flags
  logic signed [DETW-1:0] cdet [4];
  logic signed [DETW-1:0] cdot [4];
  logic [3:0]             on_c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cdet[k] = DETW'(pc1[k]) - DETW'(pc2[k]);
      cdot[k] = DETW'(pt1[k]) + DETW'(pt2[k]);
      on_c[k] = (cdet[k] == '0) && !cdot[k][DETW-1];
    end
  end

  logic                   v3;
  segx_pkg::seg_in_t      it3;
  logic signed [DFW-1:0]  vx3, vy3;
  logic signed [DETW-1:0] d3, fa3, fb3;
  logic [3:0]             on3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      it3 <= it2;
      vx3 <= vx2;
      vy3 <= vy2;
      d3  <= DETW'(pd1) - DETW'(pd2);
      fa3 <= DETW'(pa1) - DETW'(pa2);
      fb3 <= DETW'(pb1) - DETW'(pb2);
      on3 <= on_c;
    end
  end

  // stage 4: decision, signs and magnitudes
  logic signed [CW-1:0]   ep_x, ep_y;
  logic                   touch, calc, calc_hit, d_neg, strict_ok;
  logic signed [DETW-1:0] dd, ffa, ffb, fa_abs;
  logic signed [DFW-1:0]  vx_abs, vy_abs;
  segx_pkg::side_t        side_c;

  always_comb begin
    ep_x = it3.a_end_x;
    ep_y = it3.a_end_y;
    if (on3[0]) begin
      ep_x = it3.b_start_x;
      ep_y = it3.b_start_y;
    end else if (on3[1]) begin
      ep_x = it3.b_end_x;
      ep_y = it3.b_end_y;
    end else if (on3[2]) begin
      ep_x = it3.a_start_x;
      ep_y = it3.a_start_y;
    end
    touch = (it3.kind == segx_pkg::KIND_TOUCH) && (|on3);

    d_neg = d3[DETW-1];
    dd    = d_neg ? -d3 : d3;
    ffa   = d_neg ? -fa3 : fa3;
    ffb   = d_neg ? -fb3 : fb3;
    strict_ok = !ffa[DETW-1] && (ffa != '0) && (ffa < dd) &&
                !ffb[DETW-1] && (ffb != '0) && (ffb < dd);

    case (it3.kind)
      segx_pkg::KIND_STRICT, segx_pkg::KIND_TOUCH: calc = (d3 != '0) && strict_ok;
      segx_pkg::KIND_LINE:                         calc = (d3 != '0);
      default:                                     calc = 1'b0;
    endcase
    calc_hit = !touch && calc;

    fa_abs = fa3[DETW-1] ? -fa3 : fa3;
    vx_abs = vx3[DFW-1] ? -vx3 : vx3;
    vy_abs = vy3[DFW-1] ? -vy3 : vy3;

    side_c.hit    = touch || calc_hit;
    side_c.use_q  = calc_hit;
    side_c.neg_x  = fa3[DETW-1] ^ vx3[DFW-1] ^ d_neg;
    side_c.neg_y  = fa3[DETW-1] ^ vy3[DFW-1] ^ d_neg;
    side_c.base_x = touch ? ep_x : it3.a_start_x;
    side_c.base_y = touch ? ep_y : it3.a_start_y;
  end

  logic              v4;
  segx_pkg::side_t   side4;
  logic [MAGW-1:0]   fam4, dm4;
  logic [CW-1:0]     vxm4, vym4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side4 <= side_c;
      fam4  <= fa_abs[MAGW-1:0];
      dm4   <= dd[MAGW-1:0];
      vxm4  <= vx_abs[CW-1:0];
      vym4  <= vy_abs[CW-1:0];
    end
  end

  // stage 5: |fa| * |v|
  logic            v5;
  segx_pkg::side_t side5;
  logic [MW-1:0]   nx5, ny5;
  logic [MAGW-1:0] dm5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (advance) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side5 <= side4;
      dm5   <= dm4;
      nx5   <= MW'(fam4) * MW'(vxm4);
      ny5   <= MW'(fam4) * MW'(vym4);
    end
  end

  // divider
  logic [NW-1:0]   qx, qy;
  segx_pkg::side_t side_q;

  segx_div #(
    .NUM_W (NW),
    .DEN_W (MAGW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v5),
    .num_x     (NW'(nx5) << FRAC_BITS),
    .num_y     (NW'(ny5) << FRAC_BITS),
    .den       (dm5),
    .side_in   (side5),
    .out_valid (div_valid),
    .quo_x     (qx),
    .quo_y     (qy),
    .side_out  (side_q)
  );

  // final: sign, offset, saturation
  axis_t              ax, ay;
  segx_pkg::seg_out_t res_c;

  always_comb begin
    ax = fix_axis(qx, side_q.neg_x, side_q.use_q, side_q.base_x);
    ay = fix_axis(qy, side_q.neg_y, side_q.use_q, side_q.base_y);
    res_c.hit      = side_q.hit;
    res_c.cross_x  = side_q.hit ? ax.val : '0;
    res_c.cross_y  = side_q.hit ? ay.val : '0;
    res_c.overflow = side_q.hit && (ax.ovf || ay.ovf);
  end

  // output skid
  logic               push, pop;
  logic [1:0]         cnt_next;
  segx_pkg::seg_out_t slot0, slot1, slot0_next, slot1_next;

  assign push         = div_valid && (cnt != 2'd2);
  assign result_valid = (cnt != 2'd0);
  assign pop          = result_valid && !result_stall;
  assign result       = slot0;

  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    cnt_next   = cnt;
    if (pop) begin
      slot0_next = slot1;
      if (push) begin
        if (cnt == 2'd1) begin
          slot0_next = res_c;
        end else begin
          slot1_next = res_c;
        end
      end
      cnt_next = push ? cnt : cnt - 2'd1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0_next = res_c;
      end else begin
        slot1_next = res_c;
      end
      cnt_next = cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

// File: src/segx_div.sv
module segx_div #(
  parameter int NUM_W = 66,
  parameter int DEN_W = 34
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   num_x,
  input  logic [NUM_W-1:0]   num_y,
  input  logic [DEN_W-1:0]   den,
  input  segx_pkg::side_t    side_in,
  output logic               out_valid,
  output logic [NUM_W-1:0]   quo_x,
  output logic [NUM_W-1:0]   quo_y,
  output segx_pkg::side_t    side_out
);

  logic                   vld  [NUM_W];
  logic [DEN_W-1:0]       remx [NUM_W];
  logic [DEN_W-1:0]       remy [NUM_W];
  logic [NUM_W-1:0]       accx [NUM_W];
  logic [NUM_W-1:0]       accy [NUM_W];
  logic [DEN_W-1:0]       dv   [NUM_W];
  segx_pkg::side_t        sd   [NUM_W];

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [DEN_W+NUM_W-1:0] step(
    input logic [DEN_W-1:0] rem,
    input logic [NUM_W-1:0] acc,
    input logic [DEN_W-1:0] d
  );
    logic [DEN_W:0]   trial;
    logic [NUM_W-1:0] nacc;
    logic [DEN_W-1:0] nrem;
    trial = {rem, acc[NUM_W-1]};
    nacc  = acc << 1;
    nrem  = trial[DEN_W-1:0];
    if (trial >= {1'b0, d}) begin
      nrem    = DEN_W'(trial - {1'b0, d});
      nacc[0] = 1'b1;
    end
    return {nrem, nacc};
  endfunction

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic                   vin;
    logic [DEN_W-1:0]       rx_in;
    logic [DEN_W-1:0]       ry_in;
    logic [NUM_W-1:0]       ax_in;
    logic [NUM_W-1:0]       ay_in;
    logic [DEN_W-1:0]       d_in;
    segx_pkg::side_t        s_in;
    logic [DEN_W+NUM_W-1:0] nx;
    logic [DEN_W+NUM_W-1:0] ny;

    if (i == 0) begin : g_head
      assign vin   = in_valid;
      assign rx_in = '0;
      assign ry_in = '0;
      assign ax_in = num_x;
      assign ay_in = num_y;
      assign d_in  = den;
      assign s_in  = side_in;
    end else begin : g_body
      assign vin   = vld[i-1];
      assign rx_in = remx[i-1];
      assign ry_in = remy[i-1];
      assign ax_in = accx[i-1];
      assign ay_in = accy[i-1];
      assign d_in  = dv[i-1];
      assign s_in  = sd[i-1];
    end

    assign nx = step(rx_in, ax_in, d_in);
    assign ny = step(ry_in, ay_in, d_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx[i] <= nx[DEN_W+NUM_W-1:NUM_W];
        accx[i] <= nx[NUM_W-1:0];
        remy[i] <= ny[DEN_W+NUM_W-1:NUM_W];
        accy[i] <= ny[NUM_W-1:0];
        dv[i]   <= d_in;
        sd[i]   <= s_in;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo_x     = accx[NUM_W-1];
  assign quo_y     = accy[NUM_W-1];
  assign side_out  = sd[NUM_W-1];

endmodule

// File: dv/segment_intersection_tb.sv
`timescale 1ns / 100ps

module segment_intersection_tb;

  localparam int FRAC_BITS = 16;
  localparam int PIPE_LATENCY = FRAC_BITS + 55;
  localparam int RANDOM_PAIRS = 1950;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  segx_pkg::seg_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  segx_pkg::seg_out_t result;

  segx_pkg::seg_out_t awaited_crossings[$];
  bit free_run = 1'b0;
  int pairs_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int saturated_seen = 0;
  int mismatches = 0;

  segment_intersection #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL segment_intersection");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  function automatic bit on_segment(longint fx, longint fy, longint tx, longint ty,
                                    longint px, longint py);
    longint ux, uy, wx, wy;
    ux = fx - px;
    uy = fy - py;
    wx = px - tx;
    wy = py - ty;
    return cross2(ux, uy, wx, wy) == 0 && ux * wx + uy * wy >= 0;
  endfunction

  function automatic longint saturate48(longint v, inout bit ovf);
    if (v > SAT_HI) begin
      ovf = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      ovf = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  // base * 2^FRAC_BITS + trunc(fa * v * 2^FRAC_BITS / d), saturated to 48 bits; d nonzero
  function automatic longint fixed_axis(longint fa, longint v, longint d, longint base,
                                        inout bit ovf);
    bit neg;
    logic [127:0] num, quo;
    longint sq;
    neg = ((fa < 0) != (v < 0)) != (d < 0);
    num = 128'(magnitude(fa)) * 128'(magnitude(v));
    num = num << FRAC_BITS;
    quo = num / 128'(magnitude(d));
    if (quo >= (128'd1 << 62)) begin
      ovf = 1'b1;
      return neg ? SAT_LO : SAT_HI;
    end
    sq = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    return saturate48(sq + base * (64'sd1 <<< FRAC_BITS), ovf);
  endfunction

  function automatic segx_pkg::seg_out_t predict_crossing(segx_pkg::seg_in_t it);
    segx_pkg::seg_out_t r;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint px, py, sx, sy, vx, vy, wx, wy, d, fa, fb, dd, nfa, nfb;
    bit hit, ovf, touch;
    logic [1:0] k;
    ax0 = $signed(it.a_start_x);
    ay0 = $signed(it.a_start_y);
    ax1 = $signed(it.a_end_x);
    ay1 = $signed(it.a_end_y);
    bx0 = $signed(it.b_start_x);
    by0 = $signed(it.b_start_y);
    bx1 = $signed(it.b_end_x);
    by1 = $signed(it.b_end_y);
    k = it.kind;
    hit = 1'b0;
    ovf = 1'b0;
    px = 0;
    py = 0;
    if (k == segx_pkg::KIND_TOUCH) begin
      touch = 1'b1;
      if (on_segment(ax0, ay0, ax1, ay1, bx0, by0)) begin
        px = bx0;
        py = by0;
      end else if (on_segment(ax0, ay0, ax1, ay1, bx1, by1)) begin
        px = bx1;
        py = by1;
      end else if (on_segment(bx0, by0, bx1, by1, ax0, ay0)) begin
        px = ax0;
        py = ay0;
      end else if (on_segment(bx0, by0, bx1, by1, ax1, ay1)) begin
        px = ax1;
        py = ay1;
      end else begin
        touch = 1'b0;
      end
      if (touch) begin
        hit = 1'b1;
        px = saturate48(px * (64'sd1 <<< FRAC_BITS), ovf);
        py = saturate48(py * (64'sd1 <<< FRAC_BITS), ovf);
      end else begin
        k = segx_pkg::KIND_STRICT;
      end
    end
    if (!hit && (k == segx_pkg::KIND_STRICT || k == segx_pkg::KIND_LINE)) begin
      sx = bx0 - ax0;
      sy = by0 - ay0;
      vx = ax1 - ax0;
      vy = ay1 - ay0;
      wx = bx0 - bx1;
      wy = by0 - by1;
      d = cross2(vx, vy, wx, wy);
      fa = cross2(sx, sy, wx, wy);
      fb = cross2(vx, vy, sx, sy);
      if (d != 0) begin
        if (k == segx_pkg::KIND_LINE) begin
          hit = 1'b1;
        end else begin
          dd = (d < 0) ? -d : d;
          nfa = (d < 0) ? -fa : fa;
          nfb = (d < 0) ? -fb : fb;
          hit = nfa > 0 && nfa < dd && nfb > 0 && nfb < dd;
        end
        if (hit) begin
          px = fixed_axis(fa, vx, d, ax0, ovf);
          py = fixed_axis(fa, vy, d, ay0, ovf);
        end
      end
    end
    if (!hit) begin
      px = 0;
      py = 0;
      ovf = 1'b0;
    end
    r.hit = hit;
    r.cross_x = px[segx_pkg::OUT_W-1:0];
    r.cross_y = py[segx_pkg::OUT_W-1:0];
    r.overflow = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int idle_len();
    int r;
    if (free_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic segx_pkg::seg_in_t make_pair(logic [1:0] k, int ax0, int ay0,
                                                  int ax1, int ay1, int bx0, int by0,
                                                  int bx1, int by1);
    segx_pkg::seg_in_t it;
    it.kind = k;
    it.a_start_x = 16'(ax0);
    it.a_start_y = 16'(ay0);
    it.a_end_x = 16'(ax1);
    it.a_end_y = 16'(ay1);
    it.b_start_x = 16'(bx0);
    it.b_start_y = 16'(by0);
    it.b_end_x = 16'(bx1);
    it.b_end_y = 16'(by1);
    return it;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return -1;
      3: return 0;
      default: return spread(2);
    endcase
  endfunction

  function automatic segx_pkg::seg_in_t random_pair();
    segx_pkg::seg_in_t it;
    int sel, px, py, dx, dy, t, j, m, y0, y1;
    logic [1:0] k;
    sel = $urandom_range(0, 99);
    k = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
    if (sel < 25) begin
      it = make_pair(k, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 35) begin
      it = make_pair(k, corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                     corner_coord(), corner_coord(), corner_coord(), corner_coord());
    end else if (sel < 55) begin
      it = make_pair(k, spread(3), spread(3), spread(3), spread(3),
                     spread(3), spread(3), spread(3), spread(3));
    end else if (sel < 72) begin
      it = make_pair(k, spread(100), spread(100), spread(100), spread(100),
                     spread(100), spread(100), spread(100), spread(100));
      case ($urandom_range(0, 3))
        0: begin
          it.b_start_x = it.a_end_x;
          it.b_start_y = it.a_end_y;
        end
        1: begin
          it.b_end_x = it.a_start_x;
          it.b_end_y = it.a_start_y;
        end
        2: begin
          it.a_start_x = it.b_end_x;
          it.a_start_y = it.b_end_y;
        end
        default: begin
          it.a_end_x = it.b_start_x;
          it.a_end_y = it.b_start_y;
        end
      endcase
    end else if (sel < 88) begin
      // collinear or overlapping pairs along a common direction, sometimes with B's end moved off it
      px = spread(1000);
      py = spread(1000);
      dx = spread(5);
      dy = spread(5);
      t = $urandom_range(0, 40);
      j = int'($urandom_range(0, t + 20)) - 10;
      m = spread(15);
      it = make_pair(k, px, py, px + t * dx, py + t * dy,
                     px + j * dx, py + j * dy, px + (j + m) * dx, py + (j + m) * dy);
      if ($urandom_range(0, 3) == 0) begin
        it.b_end_x = 16'(spread(1000));
        it.b_end_y = 16'(spread(1000));
      end
    end else begin
      // long, nearly parallel lines: far-away crossings and saturation
      if ($urandom_range(0, 2) != 0) k = segx_pkg::KIND_LINE;
      y0 = int'($urandom_range(0, 65530)) - 32768;
      y1 = int'($urandom_range(0, 65530)) - 32768;
      it = make_pair(k, -32768 + int'($urandom_range(0, 3)), y0,
                     32767 - int'($urandom_range(0, 3)), y0 + int'($urandom_range(0, 2)),
                     -32768 + int'($urandom_range(0, 3)), y1,
                     32767 - int'($urandom_range(0, 3)), y1 + int'($urandom_range(0, 2)));
      if ($urandom_range(0, 1) == 1) begin
        it = make_pair(k, it.a_start_y, it.a_start_x, it.a_end_y, it.a_end_x,
                       it.b_start_y, it.b_start_x, it.b_end_y, it.b_end_x);
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- driver and checker

  task automatic send_item(segx_pkg::seg_in_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    awaited_crossings = {awaited_crossings, predict_crossing(it)};
    pairs_sent++;
  endtask

  task automatic report_mismatch(string what, segx_pkg::seg_out_t want,
                                 segx_pkg::seg_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): expected hit=%0b x=%0d y=%0d ovf=%0b", $time, what,
               want.hit, $signed(want.cross_x), $signed(want.cross_y), want.overflow);
      $display("    got hit=%0b x=%0d y=%0d ovf=%0b",
               got.hit, $signed(got.cross_x), $signed(got.cross_y), got.overflow);
    end
  endtask

  always @(posedge clk) begin
    segx_pkg::seg_out_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (result.hit) hits_seen++;
      if (result.overflow) saturated_seen++;
      if (awaited_crossings.size() == 0) begin
        report_mismatch("nothing pending", '0, result);
      end else begin
        want = awaited_crossings.pop_front();
        if (want.hit !== result.hit || want.cross_x !== result.cross_x ||
            want.cross_y !== result.cross_y || want.overflow !== result.overflow)
          report_mismatch("field", want, result);
      end
    end
  end

  initial begin
    int n;
    forever begin
      n = idle_len();
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_strict_crossing();
    send_item(make_pair(segx_pkg::KIND_STRICT, -10, 0, 10, 0, 0, -10, 0, 10));
    send_item(make_pair(segx_pkg::KIND_STRICT, 0, 0, 3, 0, 1, -1, 2, 2));
    send_item(make_pair(segx_pkg::KIND_STRICT, 0, 0, 10, 0, 10, 0, 10, 5));
    send_item(make_pair(segx_pkg::KIND_STRICT, 0, 0, 1, 0, 5, -1, 5, 1));
    send_item(make_pair(segx_pkg::KIND_STRICT, 0, 0, 1, 1, 0, 1, 1, 2));
  endtask

  task automatic test_touch_order();
    send_item(make_pair(segx_pkg::KIND_TOUCH, 0, 0, 10, 0, 4, 0, 4, 7));
    send_item(make_pair(segx_pkg::KIND_TOUCH, 0, 0, 10, 0, 4, 7, 6, 0));
    send_item(make_pair(segx_pkg::KIND_TOUCH, 0, 0, 5, 5, -3, 0, 3, 0));
    send_item(make_pair(segx_pkg::KIND_TOUCH, 5, 5, 0, 0, -3, 0, 3, 0));
    send_item(make_pair(segx_pkg::KIND_TOUCH, 0, 0, 10, 10, 5, 5, 20, 20));
    send_item(make_pair(segx_pkg::KIND_TOUCH, -10, 0, 10, 0, 0, -10, 0, 10));
    send_item(make_pair(segx_pkg::KIND_TOUCH, 3, 3, 3, 3, 3, 3, 3, 3));
    send_item(make_pair(segx_pkg::KIND_TOUCH, 0, 0, 1, 0, 5, -1, 5, 1));
  endtask

  task automatic test_line_mode();
    send_item(make_pair(segx_pkg::KIND_LINE, 0, 0, 1, 1, 10, 0, 11, -1));
    send_item(make_pair(segx_pkg::KIND_LINE, 0, 0, 1, 1, 0, 1, 1, 2));
    send_item(make_pair(segx_pkg::KIND_LINE, 0, 0, 2, 2, 5, 5, 9, 9));
  endtask

  task automatic test_unused_kind();
    send_item(make_pair(KIND_UNUSED, -10, 0, 10, 0, 0, -10, 0, 10));
  endtask

  task automatic test_extremes();
    send_item(make_pair(segx_pkg::KIND_TOUCH, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, -32768));
    send_item(make_pair(segx_pkg::KIND_TOUCH, 32767, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767));
    send_item(make_pair(segx_pkg::KIND_LINE, -32768, -32768, 32767, 32767,
                        -32768, 32767, 32767, -32768));
    send_item(make_pair(segx_pkg::KIND_STRICT, -32768, -32768, 32767, 32767,
                        -32768, 32767, 32767, -32768));
  endtask

  task automatic test_saturation();
    send_item(make_pair(segx_pkg::KIND_LINE, -32768, 0, 32767, 1, -32768, 2, 32766, 3));
    send_item(make_pair(segx_pkg::KIND_LINE, -32768, 0, 32767, 1,
                        -32768, 32766, 32766, 32767));
    send_item(make_pair(segx_pkg::KIND_LINE, -32768, 2, 32766, 3, -32768, 0, 32767, 1));
    send_item(make_pair(segx_pkg::KIND_LINE, 0, -32768, 1, 32767,
                        32766, -32768, 32767, 32766));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) free_run = ($urandom_range(0, 3) == 0);
      send_item(random_pair());
    end
    free_run = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_strict_crossing();
    test_touch_order();
    test_line_mode();
    test_unused_kind();
    test_extremes();
    test_saturation();
    test_random(RANDOM_PAIRS);
    item_valid <= 1'b0;
    while (awaited_crossings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    $display("%0d segment pairs sent, %0d results checked", pairs_sent, results_seen);
    $display("%0d reported a point, %0d saturated, %0d mismatches",
             hits_seen, saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS segment_intersection");
    end else begin
      $display("FAIL segment_intersection");
    end
    $finish;
  end

endmodule
